FILE: hw/rtl/stopword_hash_set_top_assert.svh
`ifndef STOPWORD_HASH_SET_TOP_ASSERT_SVH
`define STOPWORD_HASH_SET_TOP_ASSERT_SVH
// Assertion helpers for the hash set block.
`define SHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/shs_pkg.sv
`default_nettype none
package shs_pkg;
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_LOAD_BYTE = 3'd1,
    OP_LOAD_END = 3'd2,
    OP_QUERY_BYTE = 3'd3,
    OP_QUERY_END = 3'd4
  } op_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_LONG = 2'd2
  } status_t;
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_READ,
    BK_CHECK,
    BK_CMP,
    BK_CMPCHK,
    BK_WRITE,
    BK_DONE
  } bk_state_t;
  localparam logic [31:0] HASH_START = 32'd5381;
  localparam logic [7:0] SEPARATOR = 8'd32;
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_QUERY
  } cmd_kind_t;
endpackage
`default_nettype wire

FILE: hw/rtl/shs_front.sv
`default_nettype none
module shs_front #(
  parameter int MAX_WORD_LEN = 16,
  parameter int LW = $clog2(MAX_WORD_LEN + 2),
  parameter int BW = $clog2(MAX_WORD_LEN)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              back_busy,
  output logic                   busy,
  output logic                   cmd_valid,
  output shs_pkg::cmd_kind_t     cmd_kind,
  output logic                   cmd_report,
  output logic [LW-1:0]          cmd_len,
  output logic [31:0]            cmd_hash,
  output logic [MAX_WORD_LEN*8-1:0] cmd_word
);
  import shs_pkg::*;
  logic [LW-1:0] len_r, len_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [7:0] buf_r [MAX_WORD_LEN];
  logic acc;
  logic add, fin;
  cmd_kind_t kind_c;
  logic rep_c;
  assign busy = back_busy || cmd_valid;
  assign acc = start && !busy;
  always_comb begin
    add = 1'b0;
    fin = 1'b0;
    kind_c = CMD_LOAD;
    rep_c = 1'b0;
    case (in_opcode)
      OP_CLEAR: begin
        fin = 1'b1;
        kind_c = CMD_CLEAR;
      end
      OP_LOAD_BYTE: begin
        if (in_data_byte == SEPARATOR) fin = 1'b1;
        else add = 1'b1;
      end
      OP_LOAD_END: begin
        fin = 1'b1;
        rep_c = 1'b1;
      end
      OP_QUERY_BYTE: add = 1'b1;
      OP_QUERY_END: begin
        fin = 1'b1;
        rep_c = 1'b1;
        kind_c = CMD_QUERY;
      end
      default: ;
    endcase
    len_nxt = len_r;
    hash_nxt = hash_r;
    if (acc && add) begin
      if (len_r < LW'(MAX_WORD_LEN)) begin
        hash_nxt = (hash_r << 5) + hash_r + {24'd0, in_data_byte};
        len_nxt = len_r + 1'b1;
      end else begin
        len_nxt = LW'(MAX_WORD_LEN + 1);
      end
    end else if (acc && fin) begin
      len_nxt = '0;
      hash_nxt = HASH_START;
    end
  end
  logic cv_r, ck_rep_r;
  cmd_kind_t ck_r;
  logic [LW-1:0] cl_r;
  logic [31:0] ch_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      hash_r <= HASH_START;
      cv_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      hash_r <= hash_nxt;
      cv_r <= acc && fin;
    end
    if (acc && add && len_r < LW'(MAX_WORD_LEN)) buf_r[len_r[BW-1:0]] <= in_data_byte;
    if (acc && fin) begin
      ck_r <= kind_c;
      ck_rep_r <= rep_c;
      cl_r <= len_r;
      ch_r <= hash_r;
    end
  end
  logic [MAX_WORD_LEN*8-1:0] w_r;
  always_ff @(posedge clk) begin
    if (acc && fin) begin
      for (int i = 0; i < MAX_WORD_LEN; i++) w_r[i*8 +: 8] <= buf_r[i];
    end
  end
  assign cmd_valid = cv_r;
  always_comb begin
    cmd_kind = ck_r;
    cmd_report = ck_rep_r;
    cmd_len = cl_r;
    cmd_hash = ch_r;
    cmd_word = w_r;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/shs_back.sv
`default_nettype none
module shs_back #(
  parameter int TABLE_SLOTS = 256,
  parameter int MAX_WORD_LEN = 16,
  parameter int LW = $clog2(MAX_WORD_LEN + 2),
  parameter int SW = $clog2(TABLE_SLOTS),
  parameter int CW = $clog2(TABLE_SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  shs_pkg::cmd_kind_t     cmd_kind,
  input  wire logic              cmd_report,
  input  wire logic [LW-1:0]     cmd_len,
  input  wire logic [31:0]       cmd_hash,
  input  wire logic [MAX_WORD_LEN*8-1:0] cmd_word,
  output logic                   back_busy,
  output logic                   out_strobe,
  output logic                   out_found,
  output logic [1:0]             out_status,
  output logic [8:0]             out_words_stored
);
  import shs_pkg::*;
  bk_state_t st_r, st_nxt;
  logic [TABLE_SLOTS-1:0] valid_r;
  logic [LW-1:0] lenmem [TABLE_SLOTS];
  logic [MAX_WORD_LEN*8-1:0] chmem [TABLE_SLOTS];
  logic [LW-1:0] rd_len_r;
  logic [MAX_WORD_LEN*8-1:0] rd_ch_r;
  logic rd_valid_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] pend_r, pend_nxt;
  cmd_kind_t kind_r;
  logic rep_r;
  logic [LW-1:0] len_r;
  logic [MAX_WORD_LEN*8-1:0] word_r;
  logic hit_r, hit_nxt, lenok_r;
  logic eq_r;
  logic do_write, strobe_nxt;
  logic [MAX_WORD_LEN-1:0] byte_eq;
  always_comb begin
    for (int i = 0; i < MAX_WORD_LEN; i++)
      byte_eq[i] = (rd_ch_r[i*8 +: 8] == word_r[i*8 +: 8]) || (LW'(i) >= len_r);
  end
  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    hit_nxt = hit_r;
    do_write = 1'b0;
    strobe_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          idx_nxt = cmd_hash[SW-1:0];
          n_nxt = '0;
          hit_nxt = 1'b0;
          if (cmd_kind == CMD_CLEAR) st_nxt = BK_CLEAR;
          else if (cmd_len == '0) st_nxt = BK_DONE;
          else if (cmd_len > LW'(MAX_WORD_LEN)) begin
            if (cmd_kind == CMD_LOAD) pend_nxt = ST_LONG;
            st_nxt = BK_DONE;
          end else st_nxt = BK_READ;
        end
      end
      BK_CLEAR: begin
        cnt_nxt = '0;
        pend_nxt = ST_OK;
        st_nxt = BK_IDLE;
      end
      BK_READ: st_nxt = BK_CHECK;
      BK_CHECK: begin
        if (n_r == CW'(TABLE_SLOTS)) begin
          if (kind_r == CMD_LOAD) pend_nxt = ST_FULL;
          st_nxt = BK_DONE;
        end else if (!rd_valid_r) begin
          if (kind_r == CMD_LOAD) begin
            do_write = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          st_nxt = BK_DONE;
        end else st_nxt = BK_CMP;
      end
      BK_CMP: st_nxt = BK_CMPCHK;
      BK_CMPCHK: begin
        if (lenok_r && eq_r) begin
          hit_nxt = 1'b1;
          st_nxt = BK_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          n_nxt = n_r + 1'b1;
          st_nxt = BK_READ;
        end
      end
      BK_WRITE: st_nxt = BK_DONE;
      BK_DONE: begin
        strobe_nxt = rep_r;
        if (rep_r && kind_r == CMD_LOAD) pend_nxt = ST_OK;
        st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      valid_r <= '0;
      cnt_r <= '0;
      pend_r <= ST_OK;
      out_strobe <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      out_strobe <= strobe_nxt;
      if (st_r == BK_CLEAR) valid_r <= '0;
      else if (do_write) valid_r[idx_r] <= 1'b1;
    end
    if (st_r == BK_IDLE && cmd_valid) begin
      kind_r <= cmd_kind;
      rep_r <= cmd_report;
      len_r <= cmd_len;
      word_r <= cmd_word;
    end
    idx_r <= idx_nxt;
    n_r <= n_nxt;
    hit_r <= hit_nxt;
    rd_len_r <= lenmem[idx_r];
    rd_ch_r <= chmem[idx_r];
    rd_valid_r <= valid_r[idx_r];
    lenok_r <= (rd_len_r == len_r);
    eq_r <= &byte_eq;
    if (do_write) begin
      lenmem[idx_r] <= len_r;
      chmem[idx_r] <= word_r;
    end
    if (strobe_nxt) begin
      out_found <= (kind_r == CMD_QUERY) && hit_nxt;
      out_status <= (kind_r == CMD_LOAD) ? pend_r : ST_OK;
      out_words_stored <= 9'(cnt_nxt);
    end
  end
  assign back_busy = (st_r != BK_IDLE) || out_strobe;
endmodule
`default_nettype wire

FILE: hw/rtl/stopword_hash_set_top.sv
`default_nettype none
// Byte beats are taken one per cycle while busy is low; separator, end and clear beats go
// to the back end. A clear holds busy while the table empties; an empty or too-long word
// skips the search. Each probe reads a slot, checks it and compares an occupied slot's
// length and bytes; the search stops at a free slot, at a match or on a full table.
// Busy stays high through the result cycle; the receiver cannot stall.
// Reset is synchronous, active low, and empties the table at once.
module stopword_hash_set_top #(
  parameter int TABLE_SLOTS = 256,
  parameter int MAX_WORD_LEN = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_opcode,
  input  wire logic [7:0] in_data_byte,
  output logic            out_strobe,
  output logic            out_found,
  output logic [1:0]      out_status,
  output logic [8:0]      out_words_stored
);
  import shs_pkg::*;
  `include "stopword_hash_set_top_assert.svh"
  localparam int LW = $clog2(MAX_WORD_LEN + 2);
  logic back_busy, cmd_valid, cmd_report;
  cmd_kind_t cmd_kind;
  logic [LW-1:0] cmd_len;
  logic [31:0] cmd_hash;
  logic [MAX_WORD_LEN*8-1:0] cmd_word;
  shs_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
    .clk, .rst_n, .start, .in_opcode, .in_data_byte, .back_busy, .busy,
    .cmd_valid, .cmd_kind, .cmd_report, .cmd_len, .cmd_hash, .cmd_word
  );
  shs_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_kind, .cmd_report, .cmd_len, .cmd_hash,
    .cmd_word, .back_busy, .out_strobe, .out_found, .out_status, .out_words_stored
  );
  `SHS_ASSERT_IMPL(a_busy_strobe, clk, rst_n, out_strobe, busy)
  `SHS_ASSERT_NEXT(a_one_strobe, clk, rst_n, out_strobe, !out_strobe)
  `SHS_ASSERT_IMPL(a_count_range, clk, rst_n, out_strobe, out_words_stored <= 9'(TABLE_SLOTS))
endmodule
`default_nettype wire
